[src/fcpp_pkg.sv]
// Package for the framed command packet parser.
// Holds the framing constants and the result type shared by the parser core and top level.
`timescale 1ns / 1ps

package fcpp_pkg;

    localparam logic [7:0] HDR_BYTE    = 8'hA5;
    localparam logic [7:0] TAIL_BYTE   = 8'h5A;
    localparam int         MAX_PAYLOAD = 64;
    localparam int         KEPT_BYTES  = 6;
    localparam int         CNT_W       = 7;
    localparam int         IDX_W       = 3;

    localparam logic [CNT_W-1:0] MAX_COUNT  = CNT_W'(MAX_PAYLOAD);
    localparam logic [CNT_W-1:0] KEPT_COUNT = CNT_W'(KEPT_BYTES);

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_OVERRUN = 1'b1;

    typedef struct packed {
        logic        emit;
        logic        shoot_flag;
        logic        arm_request;
        logic        stop_request;
        logic        start_request;
        logic [31:0] fire_value_bits;
    } fcpp_result_t;

endpackage

[src/fcpp_frame.sv]
// Frame tracking and checksum logic of the framed command packet parser.
// Depends on fcpp_pkg for constants and the result type.
`timescale 1ns / 1ps

module fcpp_frame (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 op,
    input  logic [7:0]           rx_byte,
    output fcpp_pkg::fcpp_result_t result
);

    logic                          in_frame_reg, in_frame_next;
    logic [fcpp_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [7:0]                    bytes_reg [fcpp_pkg::KEPT_BYTES];
    logic [7:0]                    bytes_next [fcpp_pkg::KEPT_BYTES];
    logic [7:0]                    sum;
    logic                          sum_ok;

    assign sum = bytes_reg[0] + bytes_reg[1] + bytes_reg[2] + bytes_reg[3] + bytes_reg[4];
    assign sum_ok = (sum == bytes_reg[5]);

    always_comb begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        bytes_next    = bytes_reg;
        result        = '0;
        if (op == fcpp_pkg::OP_OVERRUN) begin
            in_frame_next = 1'b0;
            count_next    = '0;
            for (int i = 0; i < fcpp_pkg::KEPT_BYTES; i++) begin
                bytes_next[i] = '0;
            end
        end else if (!in_frame_reg) begin
            if (rx_byte == fcpp_pkg::HDR_BYTE) begin
                in_frame_next = 1'b1;
                count_next    = '0;
            end
        end else if (rx_byte != fcpp_pkg::TAIL_BYTE) begin
            if (count_reg >= fcpp_pkg::MAX_COUNT) begin
                in_frame_next = 1'b0;
                count_next    = '0;
            end else begin
                if (count_reg < fcpp_pkg::KEPT_COUNT) begin
                    bytes_next[count_reg[fcpp_pkg::IDX_W-1:0]] = rx_byte;
                end
                count_next = count_reg + 1'b1;
            end
        end else begin
            in_frame_next          = 1'b0;
            count_next             = '0;
            result.emit            = sum_ok;
            result.shoot_flag      = bytes_reg[0][0];
            result.arm_request     = bytes_reg[0][1];
            result.stop_request    = bytes_reg[0][2];
            result.start_request   = bytes_reg[0][3];
            result.fire_value_bits = {bytes_reg[4], bytes_reg[3], bytes_reg[2], bytes_reg[1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            for (int i = 0; i < fcpp_pkg::KEPT_BYTES; i++) begin
                bytes_reg[i] <= '0;
            end
        end else if (step) begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            bytes_reg    <= bytes_next;
        end
    end

endmodule

[src/framed_command_packet_parser.sv]
// Top level of the framed command packet parser: input register, parser core, result register.
// Depends on fcpp_pkg and fcpp_frame.
`timescale 1ns / 1ps

// Takes one received byte or overrun event per word and emits one command word for each
// frame (header 0xA5, payload, tail 0x5A) whose first five payload bytes sum modulo 256 to the
// sixth; a shorter frame is checked with the kept bytes left from before. Frames that fail
// the check, overlong frames and overrun events give no output word. A word is taken every
// cycle while the output side keeps up. A result passes from its tail byte through the input
// register and the result register, around the combinational parser logic, before it is valid
// on the output. A result waiting on the output holds the input register.

module framed_command_packet_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] op: 0 byte received, 1 overrun event
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] shoot_flag, [1] arm_request, [2] stop_request,
                                   // [3] start_request, [35:4] fire_value_bits, [39:36] zero
);

    logic                   in_valid_reg;
    logic                   in_op_reg;
    logic [7:0]             in_byte_reg;
    logic                   advance;
    fcpp_pkg::fcpp_result_t result;
    logic                   out_valid_reg, out_valid_next;
    logic [35:0]            out_data_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // hold the input word until the parser consumes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    fcpp_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .op      (in_op_reg),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_comb begin
        if (advance) begin
            out_valid_next = result.emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.emit) begin
            out_data_reg <= {result.fire_value_bits, result.start_request, result.stop_request,
                             result.arm_request, result.shoot_flag};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

endmodule

[test/fcpp_checker.sv]
// Checker for the framed command packet parser: watches both stream channels, predicts the
// command words from the accepted input words and compares them field by field.
// Depends on fcpp_pkg.
`timescale 1ns / 1ps

module fcpp_checker
    import fcpp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          mismatches,
    output int          pending,
    output int          words_taken,
    output int          commands_seen
);

    typedef struct packed {
        logic        shoot_flag;
        logic        arm_request;
        logic        stop_request;
        logic        start_request;
        logic [31:0] fire_value_bits;
    } command_t;

    logic             in_frame;
    logic [CNT_W-1:0] payload_cnt;
    logic [7:0]       kept [KEPT_BYTES];
    command_t         command_q [$];

    initial begin
        mismatches    = 0;
        pending       = 0;
        words_taken   = 0;
        commands_seen = 0;
    end

    task automatic report(input string what, input logic [39:0] want, input logic [39:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch in %s: expected %h, got %h", $time, what, want, got);
    endtask

    task automatic take_word(input logic op, input logic [7:0] b);
        logic [7:0] sum;
        command_t   cmd;
        if (op == OP_OVERRUN) begin
            in_frame    = 1'b0;
            payload_cnt = '0;
            foreach (kept[i]) kept[i] = 8'h00;
        end else if (!in_frame) begin
            if (b == HDR_BYTE) begin
                in_frame    = 1'b1;
                payload_cnt = '0;
            end
        end else if (b != TAIL_BYTE) begin
            if (payload_cnt >= MAX_COUNT) begin
                in_frame    = 1'b0;
                payload_cnt = '0;
            end else begin
                if (payload_cnt < KEPT_COUNT)
                    kept[payload_cnt[IDX_W-1:0]] = b;
                payload_cnt++;
            end
        end else begin
            in_frame    = 1'b0;
            payload_cnt = '0;
            sum = kept[0] + kept[1] + kept[2] + kept[3] + kept[4];
            if (sum == kept[5]) begin
                cmd.shoot_flag      = kept[0][0];
                cmd.arm_request     = kept[0][1];
                cmd.stop_request    = kept[0][2];
                cmd.start_request   = kept[0][3];
                cmd.fire_value_bits = {kept[4], kept[3], kept[2], kept[1]};
                command_q.push_back(cmd);
            end
        end
    endtask

    task automatic check_command(input logic [39:0] word);
        command_t want;
        commands_seen++;
        if (command_q.size() == 0) begin
            report("command word with none pending", 40'h0, word);
        end else begin
            want = command_q.pop_front();
            if (word[0] !== want.shoot_flag)
                report("shoot_flag", want.shoot_flag, word[0]);
            if (word[1] !== want.arm_request)
                report("arm_request", want.arm_request, word[1]);
            if (word[2] !== want.stop_request)
                report("stop_request", want.stop_request, word[2]);
            if (word[3] !== want.start_request)
                report("start_request", want.start_request, word[3]);
            if (word[35:4] !== want.fire_value_bits)
                report("fire_value_bits", want.fire_value_bits, word[35:4]);
            if (word[39:36] !== 4'h0)
                report("pad bits", 40'h0, word[39:36]);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            take_word(OP_OVERRUN, 8'h00);
            command_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                words_taken++;
                take_word(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready)
                check_command(m_tdata);
        end
        pending = command_q.size();
    end

endmodule

[test/tb_top.sv]
// Testbench top for the framed command packet parser: clock, reset, stimulus and verdict.
// Depends on fcpp_pkg, framed_command_packet_parser and fcpp_checker.
`timescale 1ns / 1ps

module tb_top;
    import fcpp_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = OP_BYTE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        gaps_on  = 1'b1;

    int mismatches;
    int pending;
    int words_taken;
    int commands_seen;
    int frame_words;
    int overruns;
    int pick;
    int lead;
    bit pressure_done;

    framed_command_packet_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fcpp_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .words_taken   (words_taken),
        .commands_seen (commands_seen)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk)
        m_tready <= gaps_on ? ($urandom_range(99) >= 35) : 1'b1;

    task automatic send_word(input logic op, input logic [7:0] b);
        while (gaps_on && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        // keep most frames intact; a stray tail now and then cuts one short
        if (b == TAIL_BYTE && $urandom_range(99) < 80)
            b = b ^ 8'h01;
        return b;
    endfunction

    task automatic send_frame(input int len, input bit bad_sum);
        logic [7:0] pay [$];
        logic [7:0] chk;
        for (int i = 0; i < len; i++)
            pay.push_back(payload_byte());
        if (len >= KEPT_BYTES) begin
            do begin
                chk = pay[0] + pay[1] + pay[2] + pay[3] + pay[4];
                if (bad_sum)
                    chk = chk + 8'($urandom_range(1, 255));
                if (chk == TAIL_BYTE)
                    pay[4] = payload_byte();
            end while (chk == TAIL_BYTE);
            pay[5] = chk;
        end
        send_word(OP_BYTE, HDR_BYTE);
        foreach (pay[i])
            send_word(OP_BYTE, pay[i]);
        send_word(OP_BYTE, TAIL_BYTE);
        frame_words += len + 2;
    endtask

    initial begin
        frame_words   = 0;
        overruns      = 0;
        pressure_done = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bytes while hunting, tail included
        send_word(OP_BYTE, TAIL_BYTE);
        send_word(OP_BYTE, 8'h00);
        // all flags set, value all ones, checksum 0x0B
        send_word(OP_BYTE, HDR_BYTE);
        send_word(OP_BYTE, 8'h0F);
        repeat (4) send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h0B);
        send_word(OP_BYTE, TAIL_BYTE);
        // empty frame checks against the bytes left from the last one
        send_word(OP_BYTE, HDR_BYTE);
        send_word(OP_BYTE, TAIL_BYTE);
        // overrun clears everything, so an empty frame now sums to zero
        send_word(OP_OVERRUN, 8'hFF);
        overruns++;
        send_word(OP_BYTE, HDR_BYTE);
        send_word(OP_BYTE, TAIL_BYTE);
        // header inside a frame is payload; one byte past the kept ones
        send_word(OP_BYTE, HDR_BYTE);
        send_word(OP_BYTE, HDR_BYTE);
        repeat (4) send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, HDR_BYTE);
        send_word(OP_BYTE, 8'h77);
        send_word(OP_BYTE, TAIL_BYTE);
        drain();

        while (frame_words < 850) begin
            gaps_on <= !(frame_words >= 300 && frame_words < 450);
            if (!pressure_done && frame_words >= 550) begin
                drain();
                pressure_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 66) begin
                send_frame(6, 1'b0);
            end else if (pick < 74) begin
                send_frame(6, 1'b1);
            end else if (pick < 80) begin
                send_frame($urandom_range(5), 1'b0);
            end else if (pick < 86) begin
                send_frame($urandom_range(7, 20), 1'b0);
            end else if (pick < 88) begin
                send_frame($urandom_range(63, 66), 1'b0);
            end else if (pick < 94) begin
                // overrun, mostly in the middle of a frame
                lead = $urandom_range(8);
                if (lead > 0) begin
                    send_word(OP_BYTE, HDR_BYTE);
                    for (int i = 1; i < lead; i++)
                        send_word(OP_BYTE, payload_byte());
                end
                send_word(OP_OVERRUN, 8'($urandom_range(255)));
                overruns++;
                frame_words += lead + 1;
            end else begin
                repeat ($urandom_range(1, 4))
                    send_word(OP_BYTE, 8'($urandom_range(255)));
            end
        end

        gaps_on <= 1'b0;
        drain();
        repeat (10) @(posedge aclk);
        $display("Covered %0d input words with %0d overrun events; %0d command words checked.",
                 words_taken, overruns, commands_seen);
        $display("Frames: good, bad checksum, short, long, overlong, broken by overrun or noise.");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
src/fcpp_pkg.sv
src/fcpp_frame.sv
src/framed_command_packet_parser.sv
test/fcpp_checker.sv
test/tb_top.sv
